>>> hdl/fce_pkg.sv
// ----------------------------------------------------------------------------
// fce_pkg
// shared constants, types and the crc byte update for the frame encoder
// ----------------------------------------------------------------------------
package fce_pkg;

  localparam int SampleW    = 16;
  localparam int NumSamples = 4;
  localparam int DataBytes  = 8;
  localparam int FrameBytes = 10;
  localparam int DataW      = SampleW * NumSamples;
  localparam int CrcW       = 16;
  localparam int CntW       = $clog2(FrameBytes + 1);

  localparam logic [CrcW-1:0] CrcInit = 16'hFFFF;
  localparam logic [CrcW-1:0] CrcPoly = 16'hA001;

  localparam logic [CntW-1:0] FrameLen = CntW'(FrameBytes);
  localparam logic [CntW-1:0] GapLoad  = CntW'(FrameBytes - 1);

  typedef struct packed {
    logic             valid;
    logic [DataW-1:0] data;
    logic [CrcW-1:0]  crc;
  } frame_t;

  function automatic logic [CrcW-1:0] crc_byte(input logic [CrcW-1:0] crc_in,
                                               input logic [7:0] byte_in);
    logic [CrcW-1:0] c;
    c = crc_in ^ {8'h00, byte_in};
    for (int b = 0; b < 8; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

>>> hdl/four_channel_crc16_frame_encoder.sv
// first byte of a frame reaches the out_ ports once the frame has passed the crc pipeline
// stages and been loaded into the serializer; its ten bytes come out on consecutive cycles
// the byte serializer sends one frame byte per cycle
// busy goes high after each accepted transaction; start is not taken while busy is high
// reset clears the pipeline valid bits, the serializer count and the busy counter
// ----------------------------------------------------------------------------
// four_channel_crc16_frame_encoder
// four 16-bit samples in, 10-byte frame out with crc-16/modbus trailer
// ----------------------------------------------------------------------------
module four_channel_crc16_frame_encoder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_sample_one,
  input  logic signed [15:0] in_sample_two,
  input  logic signed [15:0] in_sample_three,
  input  logic signed [15:0] in_sample_four,
  output logic               out_valid,
  output logic [7:0]         out_frame_byte,
  output logic               out_is_last
);

  localparam int ShW = 8 * fce_pkg::FrameBytes;

  logic                      accept;
  logic [fce_pkg::DataW-1:0] in_data;
  fce_pkg::frame_t           frm;

  logic [fce_pkg::CntW-1:0]  gap_r, gap_nxt;
  logic [fce_pkg::CntW-1:0]  cnt_r, cnt_nxt;
  logic [ShW-1:0]            sh_r, sh_nxt;

  assign busy    = (gap_r != '0);
  assign accept  = start && !busy;
  assign in_data = {in_sample_four, in_sample_three, in_sample_two, in_sample_one};

  fce_crc_pipe u_crc_pipe (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (accept),
    .in_data (in_data),
    .frm     (frm)
  );

  always_comb begin
    gap_nxt = gap_r;
    if (accept) begin
      gap_nxt = fce_pkg::GapLoad;
    end else if (gap_r != '0) begin
      gap_nxt = gap_r - 1'b1;
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    sh_nxt  = sh_r;
    if (frm.valid) begin
      cnt_nxt = fce_pkg::FrameLen;
      sh_nxt  = {frm.crc, frm.data};
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - 1'b1;
      sh_nxt  = sh_r >> 8;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r <= '0;
      cnt_r <= '0;
    end else begin
      gap_r <= gap_nxt;
      cnt_r <= cnt_nxt;
    end
    sh_r <= sh_nxt;
  end

  assign out_valid      = (cnt_r != '0);
  assign out_frame_byte = sh_r[7:0];
  assign out_is_last    = (cnt_r == fce_pkg::CntW'(1));

  // new frame only lands when the serializer is on its last byte or empty
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    frm.valid |-> (cnt_r <= fce_pkg::CntW'(1)))
    else $error("frame loaded over an unfinished frame");

  a_first_byte: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##9 (out_valid && (cnt_r == fce_pkg::FrameLen)))
    else $error("first frame byte not on time");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_is_last && !frm.valid) |=> !out_valid)
    else $error("bytes continue past last");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("busy not raised after accept");

endmodule

>>> hdl/fce_crc_pipe.sv
// ----------------------------------------------------------------------------
// fce_crc_pipe
// crc-16 pipeline, one data byte folded in per register stage
// ----------------------------------------------------------------------------
module fce_crc_pipe (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_vld,
  input  logic [fce_pkg::DataW-1:0] in_data,
  output fce_pkg::frame_t           frm
);

  localparam int N = fce_pkg::DataBytes;

  logic [N-1:0]                vld_r;
  logic [fce_pkg::DataW-1:0]   dat_r [N];
  logic [fce_pkg::CrcW-1:0]    crc_r [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic                      vld_nxt;
    logic [fce_pkg::DataW-1:0] dat_nxt;
    logic [fce_pkg::CrcW-1:0]  crc_prev;

    if (k == 0) begin : g_first
      assign vld_nxt  = in_vld;
      assign dat_nxt  = in_data;
      assign crc_prev = fce_pkg::CrcInit;
    end else begin : g_rest
      assign vld_nxt  = vld_r[k-1];
      assign dat_nxt  = dat_r[k-1];
      assign crc_prev = crc_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_nxt;
      end
      dat_r[k] <= dat_nxt;
      crc_r[k] <= fce_pkg::crc_byte(crc_prev, dat_nxt[8*k +: 8]);
    end
  end

  assign frm.valid = vld_r[N-1];
  assign frm.data  = dat_r[N-1];
  assign frm.crc   = crc_r[N-1];

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// checks the four-channel frame encoder byte by byte: every accepted
// transaction of four samples is turned into its ten expected frame bytes
// (samples low byte first, then a crc-16/modbus trailer) and each strobed
// output byte is compared with the oldest expected one
// ----------------------------------------------------------------------------
module testbench;

  localparam logic [15:0] ModbusSeed    = 16'hFFFF;
  localparam logic [15:0] ModbusPoly    = 16'hA001;
  localparam int          RandomSets    = 220;
  localparam int          WatchdogLimit = 2000;
  localparam int          TailCycles    = 20;

  typedef struct packed {
    logic signed [fce_pkg::SampleW-1:0] one;
    logic signed [fce_pkg::SampleW-1:0] two;
    logic signed [fce_pkg::SampleW-1:0] three;
    logic signed [fce_pkg::SampleW-1:0] four;
  } sample_set_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       is_last;
  } frame_byte_t;

  logic                               clk = 1'b0;
  logic                               rst_n = 1'b0;
  logic                               start = 1'b0;
  logic                               busy;
  logic signed [fce_pkg::SampleW-1:0] in_sample_one = '0;
  logic signed [fce_pkg::SampleW-1:0] in_sample_two = '0;
  logic signed [fce_pkg::SampleW-1:0] in_sample_three = '0;
  logic signed [fce_pkg::SampleW-1:0] in_sample_four = '0;
  logic                               out_valid;
  logic [7:0]                         out_frame_byte;
  logic                               out_is_last;

  sample_set_t sample_q[$];
  frame_byte_t frame_byte_q[$];
  int          sets_sent = 0;
  int          mismatches = 0;
  int          idle_cycles = 0;
  bit          draining = 1'b0;

  four_channel_crc16_frame_encoder DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_sample_one   (in_sample_one),
    .in_sample_two   (in_sample_two),
    .in_sample_three (in_sample_three),
    .in_sample_four  (in_sample_four),
    .out_valid       (out_valid),
    .out_frame_byte  (out_frame_byte),
    .out_is_last     (out_is_last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // crc over the eight data bytes, processed as one lsb-first bit stream
  function automatic logic [15:0] modbus_crc_of(input sample_set_t s);
    logic [63:0] stream;
    logic [15:0] crc;
    logic        fb;
    stream = {s.four, s.three, s.two, s.one};
    crc = ModbusSeed;
    for (int i = 0; i < 64; i++) begin
      fb = crc[0] ^ stream[i];
      crc = crc >> 1;
      if (fb) begin
        crc = crc ^ ModbusPoly;
      end
    end
    return crc;
  endfunction

  task automatic push_frame_bytes(input sample_set_t s);
    logic [15:0] words[5];
    frame_byte_t fb;
    words[0] = s.one;
    words[1] = s.two;
    words[2] = s.three;
    words[3] = s.four;
    words[4] = modbus_crc_of(s);
    for (int k = 0; k < fce_pkg::FrameBytes; k++) begin
      fb.frame_byte = (k % 2 == 0) ? words[k / 2][7:0] : words[k / 2][15:8];
      fb.is_last = (k == fce_pkg::FrameBytes - 1);
      frame_byte_q.push_back(fb);
    end
  endtask

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic sample_set_t make_set(input logic [15:0] a, input logic [15:0] b,
                                           input logic [15:0] c, input logic [15:0] d);
    sample_set_t s;
    s.one = a;
    s.two = b;
    s.three = c;
    s.four = d;
    return s;
  endfunction

  // driver
  always @(posedge clk) begin
    sample_set_t nxt;
    bit          idle;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        push_frame_bytes(make_set(in_sample_one, in_sample_two, in_sample_three,
                                  in_sample_four));
        void'(sample_q.pop_front());
        sets_sent++;
        if (sets_sent == 12 || sets_sent == 150) begin
          draining = 1'b1;
        end
      end
      if (draining && frame_byte_q.size() == 0) begin
        draining = 1'b0;
      end
      idle = (sets_sent < 60 || sets_sent >= 140) && ($urandom_range(99) < 15);
      if (start && busy) begin
        // transaction not taken yet, hold it
      end else if (sample_q.size() > 0 && !draining && !idle) begin
        nxt = sample_q[0];
        start <= 1'b1;
        in_sample_one <= nxt.one;
        in_sample_two <= nxt.two;
        in_sample_three <= nxt.three;
        in_sample_four <= nxt.four;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    frame_byte_t want;
    if (rst_n && out_valid) begin
      if (frame_byte_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected byte %02h last %0b", out_frame_byte, out_is_last);
        end
      end else begin
        want = frame_byte_q.pop_front();
        if (out_frame_byte !== want.frame_byte || out_is_last !== want.is_last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("byte mismatch: expected %02h last %0b, got %02h last %0b",
                     want.frame_byte, want.is_last, out_frame_byte, out_is_last);
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
        $display("watchdog: no transaction for %0d cycles", idle_cycles);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    sample_q.push_back(make_set(16'h0000, 16'h0000, 16'h0000, 16'h0000));
    sample_q.push_back(make_set(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    sample_q.push_back(make_set(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
    sample_q.push_back(make_set(16'h8000, 16'h8000, 16'h8000, 16'h8000));
    sample_q.push_back(make_set(16'h7FFF, 16'h8000, 16'hFFFF, 16'h0000));
    sample_q.push_back(make_set(16'h0001, 16'hFFFE, 16'h8001, 16'h7FFE));
    sample_q.push_back(make_set(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA));
    sample_q.push_back(make_set(16'h00FF, 16'hFF00, 16'h0F0F, 16'hF0F0));
    sample_q.push_back(make_set(16'h0102, 16'h0304, 16'h0506, 16'h0708));
    sample_q.push_back(make_set(16'hFF9C, 16'h0064, 16'hFC18, 16'h03E8));
    sample_q.push_back(make_set(16'h1234, 16'h0000, 16'h0000, 16'h0000));
    sample_q.push_back(make_set(16'h0000, 16'h0000, 16'h0000, 16'h8000));
    for (int i = 0; i < RandomSets; i++) begin
      sample_q.push_back(make_set(pick_sample(), pick_sample(), pick_sample(),
                                  pick_sample()));
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    while (sample_q.size() > 0 || frame_byte_q.size() > 0) begin
      @(negedge clk);
    end
    repeat (TailCycles) @(negedge clk);
    if (mismatches == 0 && frame_byte_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      if (frame_byte_q.size() != 0) begin
        $display("%0d expected bytes never arrived", frame_byte_q.size());
      end
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
